// ----- src/e2q_pkg.sv -----
// Shared constants, payload types and the arctangent helper function for the Euler-to-quaternion unit.
`default_nettype none

package e2q_pkg;

	// Field widths of the angle and quaternion items.
	localparam int ANGLE_BITS = 16;
	localparam int QUAT_BITS  = 16;

	// The three angles are worked on side by side, one lane each.
	localparam int LANES      = 3;
	localparam int LANE_ROLL  = 0;
	localparam int LANE_PITCH = 1;
	localparam int LANE_YAW   = 2;

	// CORDIC datapath and product widths (Q30 fixed point throughout).
	localparam int CORDIC_STEPS = 30;
	localparam int CW           = 34;
	localparam int PW           = 32;
	localparam int PROD_W       = 2 * PW;
	localparam int PROD_SHIFT   = 30;
	localparam int SUM_W        = PW + 1;
	localparam int OUT_W        = SUM_W + 2;

	// Scaling of a Q3 angle to a Q30 half angle.
	localparam int ANGLE_SHIFT = 32 - ANGLE_BITS;

	localparam logic signed [CW-1:0] Q30_HALF_PI = CW'(64'sd1686629713);
	localparam logic signed [CW-1:0] Q30_PI      = CW'(64'sd3373259426);
	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(64'sd652032874);

	localparam logic signed [PROD_W-1:0] PROD_RND = PROD_W'(64'sd1 <<< (PROD_SHIFT - 1));

	// Output quantisation: round half up to QUAT_BITS-1 fraction bits, or double at 32 bits.
	localparam int QUAT_SHIFT  = (QUAT_BITS <= 31) ? (31 - QUAT_BITS) : 0;
	localparam bit QUAT_DOUBLE = (QUAT_BITS == 32);
	localparam int QUAT_RPOS   = (QUAT_SHIFT > 0) ? (QUAT_SHIFT - 1) : 0;
	localparam logic signed [OUT_W-1:0] QUAT_RND =
		(QUAT_SHIFT > 0) ? OUT_W'(64'sd1 <<< QUAT_RPOS) : '0;
	localparam logic signed [OUT_W-1:0] QUAT_MAX = OUT_W'((64'sd1 <<< (QUAT_BITS - 1)) - 64'sd1);
	localparam logic signed [OUT_W-1:0] QUAT_MIN = OUT_W'(-(64'sd1 <<< (QUAT_BITS - 1)));

	// Register stages from input to the output register, and items the block can hold.
	localparam int PIPE_DEPTH = 1 + CORDIC_STEPS + 1 + 5;
	localparam int ITEM_CAP   = PIPE_DEPTH + 2;

	// Input item: the three Euler angles.
	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] roll_angle;
		logic signed [ANGLE_BITS-1:0] pitch_angle;
		logic signed [ANGLE_BITS-1:0] yaw_angle;
	} angles_t;

	// Output item: the unit quaternion.
	typedef struct packed {
		logic signed [QUAT_BITS-1:0] quat_w;
		logic signed [QUAT_BITS-1:0] quat_x;
		logic signed [QUAT_BITS-1:0] quat_y;
		logic signed [QUAT_BITS-1:0] quat_z;
	} quat_t;

	// A reduced half angle and whether the cosine and sine must be negated.
	typedef struct packed {
		logic signed [CW-1:0] z;
		logic                 flip;
	} rot_t;

	// Cosine and sine of one half angle in Q30.
	typedef struct packed {
		logic signed [PW-1:0] c;
		logic signed [PW-1:0] s;
	} cs_t;

	// Arctangent of 2^-step in Q30 radians.
	function automatic logic signed [CW-1:0] atan_q30(input int step);
		logic signed [CW-1:0] r;
		case (step)
			0:  r = CW'(64'sh3243F6A8);
			1:  r = CW'(64'sh1DAC6705);
			2:  r = CW'(64'sh0FADBAFC);
			3:  r = CW'(64'sh07F56EA6);
			4:  r = CW'(64'sh03FEAB76);
			5:  r = CW'(64'sh01FFD55B);
			6:  r = CW'(64'sh00FFFAAA);
			7:  r = CW'(64'sh007FFF55);
			8:  r = CW'(64'sh003FFFEA);
			9:  r = CW'(64'sh001FFFFD);
			10: r = CW'(64'sh000FFFFF);
			11: r = CW'(64'sh0007FFFF);
			12: r = CW'(64'sh0003FFFF);
			13: r = CW'(64'sh0001FFFF);
			14: r = CW'(64'sh0000FFFF);
			15: r = CW'(64'sh00007FFF);
			16: r = CW'(64'sh00003FFF);
			17: r = CW'(64'sh00001FFF);
			18: r = CW'(64'sh00000FFF);
			19: r = CW'(64'sh000007FF);
			20: r = CW'(64'sh000003FF);
			21: r = CW'(64'sh000001FF);
			22: r = CW'(64'sh000000FF);
			23: r = CW'(64'sh0000007F);
			24: r = CW'(64'sh0000003F);
			25: r = CW'(64'sh0000001F);
			26: r = CW'(64'sh0000000F);
			27: r = CW'(64'sh00000008);
			28: r = CW'(64'sh00000004);
			29: r = CW'(64'sh00000002);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/e2q_angle_prep.sv -----
// First pipeline stage: halves each angle into Q30 and folds it into the range of the CORDIC.
`default_nettype none

module e2q_angle_prep import e2q_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   valid,
	input  wire angles_t                angles,
	output logic                        valid_s1,
	output rot_t [LANES-1:0]            rot_s1
);

	logic signed [ANGLE_BITS-1:0] ang [LANES];
	logic signed [CW-1:0]         th  [LANES];
	rot_t [LANES-1:0]             rot_d;

	assign ang[LANE_ROLL]  = angles.roll_angle;
	assign ang[LANE_PITCH] = angles.pitch_angle;
	assign ang[LANE_YAW]   = angles.yaw_angle;

	// Scale to a Q30 half angle, then move it into [-pi/2, pi/2] by a half turn if needed.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			th[l] = CW'(ang[l]) <<< ANGLE_SHIFT;
			if (th[l] > Q30_HALF_PI) begin
				rot_d[l].z    = th[l] - Q30_PI;
				rot_d[l].flip = 1'b1;
			end else if (th[l] < -Q30_HALF_PI) begin
				rot_d[l].z    = th[l] + Q30_PI;
				rot_d[l].flip = 1'b1;
			end else begin
				rot_d[l].z    = th[l];
				rot_d[l].flip = 1'b0;
			end
		end
	end

	// The valid bit is reset; the payload simply follows it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1 <= rot_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/e2q_cordic.sv -----
// Rotation-mode CORDIC, one iteration per pipeline stage, for the three half angles at once.
`default_nettype none

module e2q_cordic import e2q_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   valid,
	input  wire rot_t [LANES-1:0]       rot,
	output logic                        valid_s32,
	output cs_t [LANES-1:0]             cs_s32
);

	// One register set per iteration; iteration k sits in pipeline stage k+2.
	logic signed [CW-1:0] x_s    [CORDIC_STEPS][LANES];
	logic signed [CW-1:0] y_s    [CORDIC_STEPS][LANES];
	logic signed [CW-1:0] z_s    [CORDIC_STEPS][LANES];
	logic                 flip_s [CORDIC_STEPS][LANES];
	logic                 valid_s[CORDIC_STEPS];

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		localparam logic signed [CW-1:0] ATAN_K = atan_q30(k);

		logic vi;

		if (k == 0) begin : g_head
			assign vi = valid;
		end else begin : g_body
			assign vi = valid_s[k-1];
		end

		// Valid bit of this iteration stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= vi;
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic signed [CW-1:0] xi;
			logic signed [CW-1:0] yi;
			logic signed [CW-1:0] zi;
			logic                 fi;

			if (k == 0) begin : g_head
				assign xi = CORDIC_GAIN;
				assign yi = '0;
				assign zi = rot[l].z;
				assign fi = rot[l].flip;
			end else begin : g_body
				assign xi = x_s[k-1][l];
				assign yi = y_s[k-1][l];
				assign zi = z_s[k-1][l];
				assign fi = flip_s[k-1][l];
			end

			// Rotate towards zero residual angle; shifts are arithmetic, so they floor.
			always_ff @(posedge clk) begin
				if (en) begin
					if (!zi[CW-1]) begin
						x_s[k][l] <= xi - (yi >>> k);
						y_s[k][l] <= yi + (xi >>> k);
						z_s[k][l] <= zi - ATAN_K;
					end else begin
						x_s[k][l] <= xi + (yi >>> k);
						y_s[k][l] <= yi - (xi >>> k);
						z_s[k][l] <= zi + ATAN_K;
					end
					flip_s[k][l] <= fi;
				end
			end
		end
	end

	// Final stage: undo the half-turn fold by negating cosine and sine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s32 <= 1'b0;
		end else if (en) begin
			valid_s32 <= valid_s[CORDIC_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				if (flip_s[CORDIC_STEPS-1][l]) begin
					cs_s32[l].c <= PW'(-x_s[CORDIC_STEPS-1][l]);
					cs_s32[l].s <= PW'(-y_s[CORDIC_STEPS-1][l]);
				end else begin
					cs_s32[l].c <= PW'(x_s[CORDIC_STEPS-1][l]);
					cs_s32[l].s <= PW'(y_s[CORDIC_STEPS-1][l]);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/e2q_combine.sv -----
// Triple products, sums and output rounding that turn half-angle cosines and sines into a quaternion.
`default_nettype none

module e2q_combine import e2q_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   valid,
	input  wire cs_t [LANES-1:0]        cs,
	output logic                        valid_s37,
	output quat_t                       quat
);

	logic                      valid_s33, valid_s34, valid_s35, valid_s36;
	logic signed [PROD_W-1:0]  p1_s33 [4];
	logic signed [PW-1:0]      cy_s33, sy_s33;
	logic signed [PW-1:0]      q_s34  [4];
	logic signed [PW-1:0]      cy_s34, sy_s34;
	logic signed [PROD_W-1:0]  p2_s35 [8];
	logic signed [PW-1:0]      r_s36  [8];
	logic signed [SUM_W-1:0]   sum_s37[4];
	logic signed [QUAT_BITS-1:0] q_out[4];

	// Q30 product rounding: add one half, then floor shift back to Q30.
	function automatic logic signed [PW-1:0] q30_round(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = (p + PROD_RND) >>> PROD_SHIFT;
		return PW'(t);
	endfunction

	// Round a Q30 component to the output format and saturate it.
	function automatic logic signed [QUAT_BITS-1:0] quantise(input logic signed [SUM_W-1:0] v);
		logic signed [OUT_W-1:0] e;
		logic signed [OUT_W-1:0] r;
		e = OUT_W'(v);
		if (QUAT_DOUBLE) begin
			r = e <<< 1;
		end else begin
			r = (e + QUAT_RND) >>> QUAT_SHIFT;
		end
		if (r > QUAT_MAX) begin
			r = QUAT_MAX;
		end else if (r < QUAT_MIN) begin
			r = QUAT_MIN;
		end
		return QUAT_BITS'(r);
	endfunction

	// Valid bits of the five combining stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s33 <= 1'b0;
			valid_s34 <= 1'b0;
			valid_s35 <= 1'b0;
			valid_s36 <= 1'b0;
			valid_s37 <= 1'b0;
		end else if (en) begin
			valid_s33 <= valid;
			valid_s34 <= valid_s33;
			valid_s35 <= valid_s34;
			valid_s36 <= valid_s35;
			valid_s37 <= valid_s36;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Roll-pitch products: cr*cp, sr*sp, sr*cp, cr*sp.
			p1_s33[0] <= cs[LANE_ROLL].c * cs[LANE_PITCH].c;
			p1_s33[1] <= cs[LANE_ROLL].s * cs[LANE_PITCH].s;
			p1_s33[2] <= cs[LANE_ROLL].s * cs[LANE_PITCH].c;
			p1_s33[3] <= cs[LANE_ROLL].c * cs[LANE_PITCH].s;
			cy_s33    <= cs[LANE_YAW].c;
			sy_s33    <= cs[LANE_YAW].s;

			// Back to Q30.
			for (int i = 0; i < 4; i++) begin
				q_s34[i] <= q30_round(p1_s33[i]);
			end
			cy_s34 <= cy_s33;
			sy_s34 <= sy_s33;

			// Multiply in the yaw terms, in the pairs the four components need.
			p2_s35[0] <= q_s34[0] * cy_s34;
			p2_s35[1] <= q_s34[1] * sy_s34;
			p2_s35[2] <= q_s34[2] * cy_s34;
			p2_s35[3] <= q_s34[3] * sy_s34;
			p2_s35[4] <= q_s34[3] * cy_s34;
			p2_s35[5] <= q_s34[2] * sy_s34;
			p2_s35[6] <= q_s34[0] * sy_s34;
			p2_s35[7] <= q_s34[1] * cy_s34;

			for (int i = 0; i < 8; i++) begin
				r_s36[i] <= q30_round(p2_s35[i]);
			end

			// Components w, x, y, z as sums and differences.
			sum_s37[0] <= SUM_W'(r_s36[0]) + SUM_W'(r_s36[1]);
			sum_s37[1] <= SUM_W'(r_s36[2]) - SUM_W'(r_s36[3]);
			sum_s37[2] <= SUM_W'(r_s36[4]) + SUM_W'(r_s36[5]);
			sum_s37[3] <= SUM_W'(r_s36[6]) - SUM_W'(r_s36[7]);
		end
	end

	// Output formatting feeds the output register directly.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			q_out[i] = quantise(sum_s37[i]);
		end
	end

	assign quat.quat_w = q_out[0];
	assign quat.quat_x = q_out[1];
	assign quat.quat_y = q_out[2];
	assign quat.quat_z = q_out[3];

endmodule

`default_nettype wire

// ----- src/e2q_out_buf.sv -----
// Output register with a skid stage, so that the pipeline stall is taken from a register.
`default_nettype none

module e2q_out_buf import e2q_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   valid,
	input  wire quat_t                  data,
	output logic                        ready,
	output logic                        out_valid,
	output quat_t                       out_data,
	input  wire logic                   stall
);

	logic  skid_valid_q;
	quat_t skid_q;
	logic  push;
	logic  pop;

	// The pipeline advances as long as the skid stage is empty.
	assign ready = !skid_valid_q;
	assign push  = valid && ready;
	assign pop   = out_valid && !stall;

	// Control: an item goes to the output register when it is free or being emptied, else to the skid stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid <= 1'b1;
			end
		end else if (pop) begin
			out_valid <= 1'b0;
		end
	end

	// Payload moves with the same decisions.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data <= skid_q;
			end
		end else if (push) begin
			if (out_valid && !pop) begin
				skid_q <= data;
			end else begin
				out_data <= data;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/euler_to_quaternion_unit.sv -----
// Top level of the Euler-angle (ZYX) to unit-quaternion converter.
//
// The angle channel takes roll, pitch and yaw as signed Q3.13 radians; the quat
// channel gives w, x, y, z as signed Q1.15, saturated below +1.0. Both channels use
// valid and stall, and an item moves at a rising edge with valid high and stall low.
// An item can be accepted in every cycle in which angle_stall is low. Its result
// passes in order through these stages: one halves and folds the angles, thirty
// run one CORDIC iteration each, one undoes the fold, five form the triple products
// and sums, and the output register holds the rounded, saturated quaternion.
// The output register is backed by a one-item skid stage. When the receiver stalls,
// the pipeline keeps moving until the skid stage fills; angle_stall then rises and
// the whole pipeline holds until the receiver takes an item. angle_stall comes
// straight from a register. Items are never dropped or repeated.
// Reset clears all valid bits and leaves no item in flight; there is no other state.
`default_nettype none

module euler_to_quaternion_unit import e2q_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   angle_valid,
	output logic                        angle_stall,
	input  wire angles_t                angle,
	output logic                        quat_valid,
	input  wire logic                   quat_stall,
	output quat_t                       quat
);

	logic             en;
	logic             valid_s1;
	rot_t [LANES-1:0] rot_s1;
	logic             valid_s32;
	cs_t [LANES-1:0]  cs_s32;
	logic             valid_s37;
	quat_t            quat_d;

	// One global advance signal for the whole pipeline.
	assign angle_stall = !en;

	e2q_angle_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (angle_valid),
		.angles   (angle),
		.valid_s1 (valid_s1),
		.rot_s1   (rot_s1)
	);

	e2q_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (valid_s1),
		.rot       (rot_s1),
		.valid_s32 (valid_s32),
		.cs_s32    (cs_s32)
	);

	e2q_combine u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (valid_s32),
		.cs        (cs_s32),
		.valid_s37 (valid_s37),
		.quat      (quat_d)
	);

	e2q_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid_s37),
		.data      (quat_d),
		.ready     (en),
		.out_valid (quat_valid),
		.out_data  (quat),
		.stall     (quat_stall)
	);

endmodule

`default_nettype wire

// ----- src/e2q_checker.sv -----
// Port-level checks for the Euler-to-quaternion unit, bound to its top level.
`default_nettype none

module e2q_checker import e2q_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  angle_valid,
	input  wire logic  angle_stall,
	input  wire logic  quat_valid,
	input  wire logic  quat_stall,
	input  wire quat_t quat
);

	localparam int OCC_W = $clog2(ITEM_CAP + 1);

	logic [OCC_W-1:0] occ_q;
	logic             acc_in;
	logic             acc_out;

	assign acc_in  = angle_valid && !angle_stall;
	assign acc_out = quat_valid && !quat_stall;

	// Items accepted and not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(acc_in) - OCC_W'(acc_out);
		end
	end

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && quat_stall |=> quat_valid && $stable(quat))
		else $error("stalled result item changed or vanished");

	// No result is offered unless an item is in flight.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid |-> occ_q != '0)
		else $error("result item offered with no item in flight");

	// The block never holds more items than its stages and buffers can carry.
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(ITEM_CAP))
		else $error("more items in flight than the pipeline can hold");

	// The input stalls only after the receiver has held back a result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(angle_stall) |-> $past(quat_valid && quat_stall))
		else $error("input stall raised without an output stall");

endmodule

bind euler_to_quaternion_unit e2q_checker u_e2q_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for euler_to_quaternion_unit against a bit-exact predictor.
module tb;
	import e2q_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Fixed-point constants of the half-angle CORDIC, all in Q30.
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint GAIN_Q30    = 64'sd652032874;
	localparam int     ROT_STEPS   = 30;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int RANDOM_PHASES   = 4;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int PRESSURE_ITEMS  = 150;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 64;
	localparam int DIRECTED_ROWS   = 21;

	// One row of the directed table; the quaternion is used only when known is set.
	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] roll;
		logic signed [ANGLE_BITS-1:0] pitch;
		logic signed [ANGLE_BITS-1:0] yaw;
		bit                           known;
		logic signed [QUAT_BITS-1:0]  w;
		logic signed [QUAT_BITS-1:0]  x;
		logic signed [QUAT_BITS-1:0]  y;
		logic signed [QUAT_BITS-1:0]  z;
	} stim_row_t;

	logic    clk;
	logic    arst_n       = 1'b0;
	logic    angle_valid  = 1'b0;
	logic    angle_stall;
	angles_t angle        = '0;
	logic    quat_valid;
	logic    quat_stall   = 1'b0;
	quat_t   quat;

	int      tx_idle_pct  = 0;
	int      rx_stall_pct = 0;
	logic    rx_hold      = 1'b0;
	logic    hold_go      = 1'b0;
	int      error_count  = 0;
	int      cycle_count  = 0;
	quat_t   expected_quats [$];

	// Arctangent of 2^-i in Q30 radians.
	longint atan_tab [ROT_STEPS] = '{
		64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6, 64'sh03FEAB76,
		64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55, 64'sh003FFFEA, 64'sh001FFFFD,
		64'sh000FFFFF, 64'sh0007FFFF, 64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF,
		64'sh00007FFF, 64'sh00003FFF, 64'sh00001FFF, 64'sh00000FFF, 64'sh000007FF,
		64'sh000003FF, 64'sh000001FF, 64'sh000000FF, 64'sh0000007F, 64'sh0000003F,
		64'sh0000001F, 64'sh0000000F, 64'sh00000008, 64'sh00000004, 64'sh00000002
	};

	// Directed items: zero angles, field extremes, both sides of the fold at
	// half angle pi/2, saturating components, gimbal lock and bit patterns.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd32767, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd32767, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{-16'sd32768, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd0, 16'sd32767, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd0, -16'sd32768, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd0, 16'sd0, 16'sd32767, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd0, 16'sd0, -16'sd32768, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd25735, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd25736, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd0, -16'sd25735, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd0, -16'sd25736, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{-16'sd25736, 16'sd0, 16'sd25736, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd12868, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd0, 16'sd12868, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd3000, -16'sd12868, -16'sd7000, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd1, -16'sd1, 16'sd1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{-16'sd1, 16'sd1, -16'sd1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd8192, -16'sd8192, 16'sd16384, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sh5555, 16'shAAAA, 16'sh2AAA, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}
	};

	euler_to_quaternion_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.angle_valid (angle_valid),
		.angle_stall (angle_stall),
		.angle       (angle),
		.quat_valid  (quat_valid),
		.quat_stall  (quat_stall),
		.quat        (quat)
	);

	// Q30 product, rounded half up with a floor shift.
	function automatic longint q30_mul(input longint a, input longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	// Cosine and sine of half the angle: fold into +-pi/2, then rotate.
	function automatic void half_angle_cos_sin(input logic signed [ANGLE_BITS-1:0] ang,
			output longint c, output longint s);
		longint th;
		longint cx;
		longint sy;
		longint zr;
		longint dx;
		longint dy;
		bit     fold;
		th   = longint'(ang) <<< (32 - ANGLE_BITS);
		fold = 1'b0;
		if (th > HALF_PI_Q30) begin
			th   = th - PI_Q30;
			fold = 1'b1;
		end else if (th < -HALF_PI_Q30) begin
			th   = th + PI_Q30;
			fold = 1'b1;
		end
		cx = GAIN_Q30;
		sy = 0;
		zr = th;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = sy >>> i;
			dy = cx >>> i;
			if (zr >= 0) begin
				cx = cx - dx;
				sy = sy + dy;
				zr = zr - atan_tab[i];
			end else begin
				cx = cx + dx;
				sy = sy - dy;
				zr = zr + atan_tab[i];
			end
		end
		c = fold ? -cx : cx;
		s = fold ? -sy : sy;
	endfunction

	// Round a Q30 component to the output fraction width and saturate it.
	function automatic logic signed [QUAT_BITS-1:0] quantise_component(input longint v);
		longint hi;
		longint lo;
		longint r;
		hi = (64'sd1 <<< (QUAT_BITS - 1)) - 1;
		lo = -hi - 1;
		if (QUAT_BITS <= 30)
			r = (v + (64'sd1 <<< (30 - QUAT_BITS))) >>> (31 - QUAT_BITS);
		else if (QUAT_BITS == 31)
			r = v;
		else
			r = v * 2;
		if (r > hi)
			r = hi;
		if (r < lo)
			r = lo;
		return QUAT_BITS'(r);
	endfunction

	// Unit quaternion of the ZYX rotation given by the three angles.
	function automatic quat_t predict_quat(input angles_t a);
		longint cr, sr, cp, sp, cy, sy;
		quat_t  q;
		half_angle_cos_sin(a.roll_angle, cr, sr);
		half_angle_cos_sin(a.pitch_angle, cp, sp);
		half_angle_cos_sin(a.yaw_angle, cy, sy);
		q.quat_w = quantise_component(q30_mul(q30_mul(cr, cp), cy) + q30_mul(q30_mul(sr, sp), sy));
		q.quat_x = quantise_component(q30_mul(q30_mul(sr, cp), cy) - q30_mul(q30_mul(cr, sp), sy));
		q.quat_y = quantise_component(q30_mul(q30_mul(cr, sp), cy) + q30_mul(q30_mul(sr, cp), sy));
		q.quat_z = quantise_component(q30_mul(q30_mul(cr, cp), sy) - q30_mul(q30_mul(sr, sp), cy));
		return q;
	endfunction

	// Random angle: mostly full range, with extremes, tiny angles and the fold edge.
	function automatic logic signed [ANGLE_BITS-1:0] random_angle();
		logic signed [ANGLE_BITS-1:0] r;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: r = 16'sd32767;
					1: r = -16'sd32768;
					2: r = 16'sd25736;
					default: r = -16'sd25736;
				endcase
			end
			1: r = ANGLE_BITS'(int'($urandom_range(128)) - 64);
			2: begin
				r = ANGLE_BITS'(25736 + int'($urandom_range(16)) - 8);
				if ($urandom_range(1))
					r = -r;
			end
			default: r = ANGLE_BITS'($urandom);
		endcase
		return r;
	endfunction

	// Offer one item, idling beforehand at the current rate, and record its result.
	task automatic send_angles(input angles_t a, input bit known, input quat_t typed_q);
		while ($urandom_range(99) < tx_idle_pct) begin
			angle_valid <= 1'b0;
			@(posedge clk);
		end
		angle_valid <= 1'b1;
		angle       <= a;
		@(posedge clk);
		while (angle_stall)
			@(posedge clk);
		expected_quats.push_back(known ? typed_q : predict_quat(a));
	endtask

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stall: a random rate, overridden by the long hold-off.
	always @(posedge clk) begin
		quat_stall <= rx_hold || ($urandom_range(99) < rx_stall_pct);
	end

	// Long hold-off of the receiver, counted here while the sender keeps offering items.
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Compare each accepted quaternion with the oldest expectation.
	always @(posedge clk) begin
		quat_t want;
		if (arst_n && quat_valid && !quat_stall) begin
			if (expected_quats.size() == 0) begin
				$error("unexpected quaternion item: w=%0d x=%0d y=%0d z=%0d",
					quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
				error_count++;
			end else begin
				want = expected_quats.pop_front();
				if (quat.quat_w !== want.quat_w) begin
					$error("quat_w: expected %0d, got %0d", want.quat_w, quat.quat_w);
					error_count++;
				end
				if (quat.quat_x !== want.quat_x) begin
					$error("quat_x: expected %0d, got %0d", want.quat_x, quat.quat_x);
					error_count++;
				end
				if (quat.quat_y !== want.quat_y) begin
					$error("quat_y: expected %0d, got %0d", want.quat_y, quat.quat_y);
					error_count++;
				end
				if (quat.quat_z !== want.quat_z) begin
					$error("quat_z: expected %0d, got %0d", want.quat_z, quat.quat_z);
					error_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Stimulus: reset, the directed table, random phases, the pressure phase, drain.
	initial begin
		int        tx_rates [RANDOM_PHASES];
		int        rx_rates [RANDOM_PHASES];
		angles_t   a;
		quat_t     q;
		stim_row_t row;

		tx_rates = '{0, 57, 0, 15};
		rx_rates = '{0, 0, 57, 15};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at full rate.
		foreach (directed_rows[i]) begin
			row           = directed_rows[i];
			a.roll_angle  = row.roll;
			a.pitch_angle = row.pitch;
			a.yaw_angle   = row.yaw;
			q.quat_w      = row.w;
			q.quat_x      = row.x;
			q.quat_y      = row.y;
			q.quat_z      = row.z;
			send_angles(a, row.known, q);
		end

		// Random phases with different idling on each side.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			tx_idle_pct  = tx_rates[ph];
			rx_stall_pct <= rx_rates[ph];
			repeat (ITEMS_PER_PHASE) begin
				a.roll_angle  = random_angle();
				a.pitch_angle = random_angle();
				a.yaw_angle   = random_angle();
				send_angles(a, 1'b0, '0);
			end
		end

		// Receiver holds off for a long stretch while items keep coming.
		tx_idle_pct  = 0;
		rx_stall_pct <= 0;
		hold_go      <= 1'b1;
		repeat (PRESSURE_ITEMS) begin
			a.roll_angle  = random_angle();
			a.pitch_angle = random_angle();
			a.yaw_angle   = random_angle();
			send_angles(a, 1'b0, '0);
		end

		// Drain and allow time for any stray item to appear.
		angle_valid <= 1'b0;
		while (expected_quats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
